// ===== rtl/core/twa_pkg.sv =====
// ============================================================================
// twa_pkg: shared types and constants of the three-axis window average
// Payload structs of both channels, the internal operation record passed
// from the front part to the back part, and the derived widths.
// ============================================================================
package twa_pkg;

    // Ring depth in samples. Must be a power of two (2 .. 1024): the mean
    // is taken with an arithmetic shift.
    localparam int DEPTH     = 16;
    localparam int LOG_DEPTH = $clog2(DEPTH);
    localparam int IDX_W     = (LOG_DEPTH < 1) ? 1 : LOG_DEPTH;
    localparam int FILL_W    = $clog2(DEPTH + 1);

    // Axis sample and running sum widths
    localparam int SAMPLE_W  = 16;
    localparam int SUM_W     = SAMPLE_W + LOG_DEPTH;
    localparam int POS_W     = 4;

    // Queue between the front and back parts
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    // Item kinds
    localparam logic KIND_PUSH   = 1'b0;
    localparam logic KIND_REWIND = 1'b1;

    typedef struct packed {
        logic                       kind;
        logic signed [SAMPLE_W-1:0] sample_x;
        logic signed [SAMPLE_W-1:0] sample_y;
        logic signed [SAMPLE_W-1:0] sample_z;
    } twa_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] mean_x;
        logic signed [SAMPLE_W-1:0] mean_y;
        logic signed [SAMPLE_W-1:0] mean_z;
        logic        [POS_W-1:0]    position;
        logic                       wrapped;
    } twa_out_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] x;
        logic signed [SAMPLE_W-1:0] y;
        logic signed [SAMPLE_W-1:0] z;
    } twa_sample_t;

    // One classified item: new sample and the sample it displaces
    typedef struct packed {
        logic                    push;
        twa_sample_t             new_smp;
        twa_sample_t             old_smp;
        logic [POS_W-1:0]        position;
        logic                    wrapped;
    } twa_op_t;

endpackage

// ===== rtl/core/twa_front.sv =====
// ============================================================================
// twa_front: input acceptance, write position and sample ring
// Accepts one item per cycle while the queue has room, steps the write
// position, writes the ring and reads the displaced sample in the same cycle.
// ============================================================================
module twa_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  twa_pkg::twa_in_t          in_data,
    input  logic [twa_pkg::QCNT_W-1:0] q_count,
    output logic                      q_push,
    output twa_pkg::twa_op_t          q_data
);

    logic [twa_pkg::IDX_W-1:0]  widx_reg;
    logic [twa_pkg::IDX_W-1:0]  widx_next;
    logic [twa_pkg::FILL_W-1:0] fill_reg;
    logic [twa_pkg::FILL_W-1:0] fill_next;

    logic                       s1_valid_reg;
    logic                       s1_push_reg;
    twa_pkg::twa_sample_t       s1_new_reg;
    logic                       s1_old_ok_reg;
    logic [twa_pkg::POS_W-1:0]  s1_pos_reg;
    logic                       s1_wrap_reg;
    twa_pkg::twa_sample_t       rd_reg;

    twa_pkg::twa_sample_t       ring_mem [twa_pkg::DEPTH];

    logic                       accept;
    logic                       push;
    logic                       at_last;
    logic [twa_pkg::QCNT_W:0]   in_use;
    logic [twa_pkg::IDX_W+twa_pkg::POS_W-1:0] pos_ext;
    twa_pkg::twa_sample_t       new_smp;

    // Reserve a queue slot for the item in the read stage
    assign in_use   = {1'b0, q_count} + {{twa_pkg::QCNT_W{1'b0}}, s1_valid_reg};
    assign in_ready = (in_use < (twa_pkg::QCNT_W + 1)'(twa_pkg::QDEPTH));

    assign accept  = in_valid && in_ready;
    assign push    = accept && (in_data.kind == twa_pkg::KIND_PUSH);
    assign at_last = (widx_reg == twa_pkg::IDX_W'(twa_pkg::DEPTH - 1));

    assign new_smp.x = in_data.sample_x;
    assign new_smp.y = in_data.sample_y;
    assign new_smp.z = in_data.sample_z;

    // Advance or rewind the write position; grow the written prefix
    always_comb
    begin
        widx_next = widx_reg;
        fill_next = fill_reg;
        if (accept)
        begin
            if (in_data.kind == twa_pkg::KIND_REWIND || at_last)
                widx_next = '0;
            else
                widx_next = widx_reg + 1'b1;
        end
        if (push && (twa_pkg::FILL_W'(widx_reg) == fill_reg))
            fill_next = fill_reg + 1'b1;
    end

    // Report the low position bits, zero-extended for small rings
    assign pos_ext = {{twa_pkg::POS_W{1'b0}}, widx_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            widx_reg     <= '0;
            fill_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            widx_reg     <= widx_next;
            fill_reg     <= fill_next;
            s1_valid_reg <= accept;
        end
    end

    // Hold the classified item for the read stage
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_push_reg   <= (in_data.kind == twa_pkg::KIND_PUSH);
            s1_new_reg    <= new_smp;
            s1_old_ok_reg <= (twa_pkg::FILL_W'(widx_reg) < fill_reg);
            s1_pos_reg    <= pos_ext[twa_pkg::POS_W-1:0];
            s1_wrap_reg   <= push && at_last;
        end
    end

    // Ring: read the displaced sample and write the new one in the same cycle
    always_ff @(posedge clk)
    begin
        if (push)
            ring_mem[widx_reg] <= new_smp;
        if (accept)
            rd_reg <= ring_mem[widx_reg];
    end

    // Slots never written since reset read as zero
    assign q_push           = s1_valid_reg;
    assign q_data.push      = s1_push_reg;
    assign q_data.new_smp   = s1_new_reg;
    assign q_data.old_smp   = s1_old_ok_reg ? rd_reg : '0;
    assign q_data.position  = s1_pos_reg;
    assign q_data.wrapped   = s1_wrap_reg;

endmodule

// ===== rtl/core/twa_queue.sv =====
// ============================================================================
// twa_queue: short FIFO between the front and back parts
// Holds classified items so the back part can stall on the output channel
// without stopping the ring update.
// ============================================================================
module twa_queue (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  twa_pkg::twa_op_t           wr_data,
    input  logic                       rd_en,
    output twa_pkg::twa_op_t           rd_data,
    output logic [twa_pkg::QCNT_W-1:0] count
);

    twa_pkg::twa_op_t              entry_reg [twa_pkg::QDEPTH];
    logic [twa_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [twa_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [twa_pkg::QCNT_W-1:0]    count_reg;
    logic [twa_pkg::QCNT_W-1:0]    count_next;

    always_comb
    begin
        unique case ({wr_en, rd_en})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (rd_en)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (wr_en)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

    assign rd_data = entry_reg[rd_ptr_reg];
    assign count   = count_reg;

endmodule

// ===== rtl/core/twa_back.sv =====
// ============================================================================
// twa_back: running sums, mean and output register
// Pops one item per cycle while the output register is free or drained,
// updates the per-axis sums and registers the result beat.
// ============================================================================
module twa_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  twa_pkg::twa_op_t           q_data,
    input  logic [twa_pkg::QCNT_W-1:0] q_count,
    output logic                       q_pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output twa_pkg::twa_out_t          out_data
);

    logic signed [twa_pkg::SUM_W-1:0] sum_x_reg, sum_y_reg, sum_z_reg;
    logic signed [twa_pkg::SUM_W-1:0] sum_x_next, sum_y_next, sum_z_next;
    logic                             out_valid_reg;
    twa_pkg::twa_out_t                out_reg;
    twa_pkg::twa_out_t                out_next;

    // Widen a sample to sum width
    function automatic logic signed [twa_pkg::SUM_W-1:0] widen(
        input logic signed [twa_pkg::SAMPLE_W-1:0] v
    );
        return {{(twa_pkg::SUM_W - twa_pkg::SAMPLE_W){v[twa_pkg::SAMPLE_W-1]}}, v};
    endfunction

    // Divide by the ring depth, truncating toward zero
    function automatic logic signed [twa_pkg::SAMPLE_W-1:0] mean_of(
        input logic signed [twa_pkg::SUM_W-1:0] s
    );
        logic signed [twa_pkg::SUM_W-1:0] adj;
        adj = s + (s[twa_pkg::SUM_W-1] ? twa_pkg::SUM_W'(twa_pkg::DEPTH - 1)
                                       : {twa_pkg::SUM_W{1'b0}});
        return adj[twa_pkg::LOG_DEPTH +: twa_pkg::SAMPLE_W];
    endfunction

    assign q_pop = (q_count != '0) && (!out_valid_reg || out_ready);

    // Add the new sample and drop the displaced one
    always_comb
    begin
        sum_x_next = sum_x_reg;
        sum_y_next = sum_y_reg;
        sum_z_next = sum_z_reg;
        if (q_data.push)
        begin
            sum_x_next = sum_x_reg + widen(q_data.new_smp.x) - widen(q_data.old_smp.x);
            sum_y_next = sum_y_reg + widen(q_data.new_smp.y) - widen(q_data.old_smp.y);
            sum_z_next = sum_z_reg + widen(q_data.new_smp.z) - widen(q_data.old_smp.z);
        end
        out_next.mean_x   = mean_of(sum_x_next);
        out_next.mean_y   = mean_of(sum_y_next);
        out_next.mean_z   = mean_of(sum_z_next);
        out_next.position = q_data.position;
        out_next.wrapped  = q_data.wrapped;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            sum_z_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                sum_x_reg <= sum_x_next;
                sum_y_reg <= sum_y_next;
                sum_z_reg <= sum_z_next;
            end
            if (q_pop)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Load the result beat
    always_ff @(posedge clk)
    begin
        if (q_pop)
            out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== rtl/core/triaxial_window_average.sv =====
// ============================================================================
// triaxial_window_average: three-axis moving average over a sample ring
// Top level joining the front part, the item queue and the back part.
// ============================================================================
// Usage:
//   Input channel in_valid / in_ready / in_data carries one item per beat:
//   kind push stores (sample_x, sample_y, sample_z) at the write position and
//   advances it; kind rewind sets the position to zero and keeps the ring.
//   Output channel out_valid / out_ready / out_data returns exactly one beat
//   per item, in order: the per-axis mean over all ring slots (truncated
//   toward zero), the write position after the item and the wrap flag.
//   Throughput: one item per cycle while out_ready stays high. The ring is
//   written and the displaced sample read in the same cycle, so successive
//   pushes never wait on the ring. Each item passes the ring read stage,
//   the queue and the sum update into the output register, which raises out_valid.
//   When the receiver stalls, the four-entry queue and the output register
//   absorb items; in_ready drops once the queue and the read stage hold four.
//   Reset clears position, sums and handshake state at once; the ring is
//   treated as all zero through a written-prefix count, so no clearing pass
//   is needed and items are accepted in the first cycle after reset.
// ============================================================================
module triaxial_window_average (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  twa_pkg::twa_in_t   in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output twa_pkg::twa_out_t  out_data
);

    logic                       q_push;
    logic                       q_pop;
    twa_pkg::twa_op_t           q_wr_data;
    twa_pkg::twa_op_t           q_rd_data;
    logic [twa_pkg::QCNT_W-1:0] q_count;

    twa_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_count  (q_count),
        .q_push   (q_push),
        .q_data   (q_wr_data)
    );

    twa_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_data),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .count   (q_count)
    );

    twa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_data    (q_rd_data),
        .q_count   (q_count),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Every accepted item reaches the queue on the next edge
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> q_push)
        else $error("accepted item did not reach the queue");

    // The credit check keeps the queue from overflowing
    assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && !q_pop && (q_count == twa_pkg::QCNT_W'(twa_pkg::QDEPTH))))
        else $error("queue overflow");

    // Never pop an empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (q_count != '0))
        else $error("queue underflow");

endmodule
